// ===== design/tlv_header_scanner_macros.svh =====
// Assertion macros for the TLV header scanner.
`ifndef TLV_HEADER_SCANNER_MACROS_SVH
`define TLV_HEADER_SCANNER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define THS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlv_header_scanner: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define THS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlv_header_scanner: next-cycle check failed");

`else

`define THS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define THS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/ths_pkg.sv =====
// Package: widths, limits and the result record of the TLV header scanner.
`timescale 1ns / 1ps
package ths_pkg;

    localparam int TAG_BITS    = 32;
    localparam int LEN_BITS    = 32;
    localparam int REGION_BITS = 16;

    // Position counter is one bit wider than the region size so it can pass it.
    localparam int POS_BITS = REGION_BITS + 1;
    // Width that holds position plus length without wrap.
    localparam int SUM_BITS = ((LEN_BITS > POS_BITS) ? LEN_BITS : POS_BITS) + 1;

    typedef logic [TAG_BITS-1:0]    t_tag;
    typedef logic [LEN_BITS-1:0]    t_len;
    typedef logic [POS_BITS-1:0]    t_pos;
    typedef logic [REGION_BITS-1:0] t_region;
    typedef logic [SUM_BITS-1:0]    t_sum;

    localparam t_pos POS_MAX = {POS_BITS{1'b1}};
    localparam t_pos OFF_MAX = {1'b0, {REGION_BITS{1'b1}}};

    localparam logic [4:0] TAG_MULTI_MARK = 5'h1F;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] length;
        logic        indefinite_length;
        logic [15:0] value_offset;
        logic        end_of_content;
        logic        overrun;
        logic        region_done;
    } t_result;

endpackage

// ===== design/ths_if.sv =====
// Interfaces: byte input channel, result channel and configuration write channel.
`timescale 1ns / 1ps
interface ths_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface ths_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] tag;
    logic [31:0] length;
    logic        indefinite_length;
    logic [15:0] value_offset;
    logic        end_of_content;
    logic        overrun;
    logic        region_done;

    modport source (output valid, output tag, output length, output indefinite_length,
                    output value_offset, output end_of_content, output overrun,
                    output region_done, input ready);
    modport sink   (input valid, input tag, input length, input indefinite_length,
                    input value_offset, input end_of_content, input overrun,
                    input region_done, output ready);
endinterface

interface ths_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] region_bytes;

    modport source (output valid, output region_bytes, input ready);
    modport sink   (input valid, input region_bytes, output ready);
endinterface

// ===== design/ths_scan_core.sv =====
// Scan core: header phase tracking, tag and length accumulation, region bookkeeping.
`timescale 1ns / 1ps
module ths_scan_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    input  ths_pkg::t_region i_region_bytes,
    output logic             o_emit,
    output ths_pkg::t_result o_result
);
    import ths_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG_FIRST,
        PH_TAG_MORE,
        PH_LEN_FIRST,
        PH_LEN_MORE,
        PH_SKIP
    } t_phase;

    t_phase     r_phase, n_phase, cur_phase;
    t_tag       r_tag, n_tag, cur_tag;
    t_len       r_len, n_len, cur_len;
    logic [6:0] r_left, n_left, cur_left, left_dec;
    t_len       r_skip, n_skip, cur_skip, skip_dec;
    t_pos       r_pos, n_pos, cur_pos, pos_inc, off_sat;
    logic       r_finished, n_finished, cur_finished;

    logic       finish, indef, eoc, ovr, done;
    t_len       len_fin, len_shift;
    t_sum       end_sum, region_ext;

    always_comb begin
        // A start request clears the scan before this byte is looked at.
        cur_phase    = r_phase;
        cur_tag      = r_tag;
        cur_len      = r_len;
        cur_left     = r_left;
        cur_skip     = r_skip;
        cur_pos      = r_pos;
        cur_finished = r_finished;
        if (i_start) begin
            cur_phase    = PH_TAG_FIRST;
            cur_tag      = '0;
            cur_len      = '0;
            cur_left     = '0;
            cur_skip     = '0;
            cur_pos      = '0;
            cur_finished = 1'b0;
        end

        n_phase    = cur_phase;
        n_tag      = cur_tag;
        n_len      = cur_len;
        n_left     = cur_left;
        n_skip     = cur_skip;
        n_pos      = cur_pos;
        n_finished = cur_finished;

        pos_inc   = (cur_pos != POS_MAX) ? cur_pos + t_pos'(1) : cur_pos;
        left_dec  = (cur_left != '0) ? cur_left - 7'd1 : cur_left;
        skip_dec  = (cur_skip != '0) ? cur_skip - t_len'(1) : cur_skip;
        len_shift = (cur_len << 8) | t_len'(i_byte);

        finish  = 1'b0;
        indef   = 1'b0;
        len_fin = '0;

        if (!cur_finished) begin
            n_pos = pos_inc;
            case (cur_phase)
                PH_TAG_FIRST: begin
                    n_tag   = t_tag'(i_byte);
                    n_phase = (i_byte[4:0] == TAG_MULTI_MARK) ? PH_TAG_MORE : PH_LEN_FIRST;
                end
                PH_TAG_MORE: begin
                    n_tag = (cur_tag << 8) | t_tag'(i_byte);
                    if (!i_byte[7]) begin
                        n_phase = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST: begin
                    if (!i_byte[7]) begin
                        finish  = 1'b1;
                        len_fin = t_len'(i_byte);
                    end else if (i_byte[6:0] == 7'd0) begin
                        finish = 1'b1;
                        indef  = 1'b1;
                    end else begin
                        n_len   = '0;
                        n_left  = i_byte[6:0];
                        n_phase = PH_LEN_MORE;
                    end
                end
                PH_LEN_MORE: begin
                    n_len  = len_shift;
                    n_left = left_dec;
                    if (left_dec == 7'd0) begin
                        finish  = 1'b1;
                        len_fin = len_shift;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = PH_TAG_FIRST;
                    end
                end
                default: begin
                    n_phase = PH_TAG_FIRST;
                end
            endcase
        end

        // Header complete: judge against the region limit.
        end_sum    = t_sum'(pos_inc) + t_sum'(len_fin);
        region_ext = t_sum'(i_region_bytes);
        eoc = 1'b0;
        ovr = 1'b0;
        if (i_region_bytes == '0) begin
            eoc = (cur_tag == '0);
        end else begin
            ovr = (end_sum > region_ext);
        end
        done = eoc || ovr || ((i_region_bytes != '0) && (end_sum == region_ext));

        if (finish) begin
            n_tag  = '0;
            n_len  = '0;
            n_left = '0;
            if (done) begin
                n_finished = 1'b1;
                n_phase    = PH_TAG_FIRST;
            end else if (len_fin != '0) begin
                n_skip  = len_fin;
                n_phase = PH_SKIP;
            end else begin
                n_phase = PH_TAG_FIRST;
            end
        end

        off_sat = (pos_inc > OFF_MAX) ? OFF_MAX : pos_inc;

        o_emit                     = finish;
        o_result.tag               = 32'(cur_tag);
        o_result.length            = 32'(len_fin);
        o_result.indefinite_length = indef;
        o_result.value_offset      = 16'(off_sat);
        o_result.end_of_content    = eoc;
        o_result.overrun           = ovr;
        o_result.region_done       = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG_FIRST;
            r_tag      <= '0;
            r_len      <= '0;
            r_left     <= '0;
            r_skip     <= '0;
            r_pos      <= '0;
            r_finished <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_tag      <= n_tag;
            r_len      <= n_len;
            r_left     <= n_left;
            r_skip     <= n_skip;
            r_pos      <= n_pos;
            r_finished <= n_finished;
        end
    end

endmodule

// ===== design/ths_out_reg.sv =====
// Result register: holds one result item until the receiver takes it.
`timescale 1ns / 1ps
module ths_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ths_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_advance,
    output logic             o_valid,
    output ths_pkg::t_result o_result
);
    import ths_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Slot is free when empty or being drained this cycle.
    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== design/tlv_header_scanner.sv =====
// Top level of the TLV header scanner: input register, scan core, result register.
//
// Usage:
//   i_byte  carries one raw byte of a flat BER-TLV region per item; set
//           start_req on the first byte of each region to restart the scan.
//   i_cfg   writes region_bytes (0 = indefinite, ends at a zero tag). Write it
//           only while the block is idle; ready is always high.
//   o_res   delivers one item per completed header (on the last length byte):
//           tag, length, value offset and end/overrun flags. Value bytes and
//           bytes after the region ends produce no item.
// Timing:
//   An accepted byte passes through the input register and the combinational
//   scan core into the result register, from which the receiver takes it.
//   One byte per cycle is taken sustained while the receiver takes each result;
//   the input register, the combinational scan core and the result register set this.
// Reset (i_rst_n low, synchronous): clears the scan state, empties both
//   registers and sets region_bytes to 0.
// Stall: while o_res holds an item the receiver does not take, the core
//   holds; the input register still takes one more byte if it is empty, then
//   i_byte.ready drops until the result is taken.
`timescale 1ns / 1ps
`include "tlv_header_scanner_macros.svh"
module tlv_header_scanner (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ths_byte_if.sink     i_byte,
    ths_cfg_if.sink      i_cfg,
    ths_result_if.source o_res
);
    import ths_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    t_region    r_region_bytes;

    logic       advance;
    logic       core_step;
    logic       core_emit;
    t_result    core_result;
    logic       out_valid;
    t_result    out_result;

    // Take a new byte whenever the input register is empty or moves on.
    assign i_byte.ready = !r_in_valid || advance;
    assign core_step    = r_in_valid && advance;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_region_bytes <= '0;
        end else begin
            if (i_byte.valid && i_byte.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_region_bytes <= t_region'(i_cfg.region_bytes);
            end
        end
    end

    // Input payload: load on accept only.
    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte  <= i_byte.data_byte;
            r_in_start <= i_byte.start_req;
        end
    end

    ths_scan_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (core_step),
        .i_byte         (r_in_byte),
        .i_start        (r_in_start),
        .i_region_bytes (r_region_bytes),
        .o_emit         (core_emit),
        .o_result       (core_result)
    );

    ths_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (core_step && core_emit),
        .i_result  (core_result),
        .i_ready   (o_res.ready),
        .o_advance (advance),
        .o_valid   (out_valid),
        .o_result  (out_result)
    );

    assign o_res.valid             = out_valid;
    assign o_res.tag               = out_result.tag;
    assign o_res.length            = out_result.length;
    assign o_res.indefinite_length = out_result.indefinite_length;
    assign o_res.value_offset      = out_result.value_offset;
    assign o_res.end_of_content    = out_result.end_of_content;
    assign o_res.overrun           = out_result.overrun;
    assign o_res.region_done       = out_result.region_done;

    // Core must hold while a result waits unclaimed.
    `THS_ASSERT_IMPLIES(a_hold_on_stall, i_clk, i_rst_n,
        out_valid && !o_res.ready, !core_step)
    // A header completed by the core shows up at the output next cycle.
    `THS_ASSERT_NEXT(a_emit_lands, i_clk, i_rst_n,
        core_step && core_emit, o_res.valid)
    // Overrun and end of content both end the region.
    `THS_ASSERT_IMPLIES(a_end_flags, i_clk, i_rst_n,
        o_res.valid && (o_res.overrun || o_res.end_of_content), o_res.region_done)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the TLV header scanner: byte stimulus, header prediction, result check.
`timescale 1ns / 1ps
module tb_top;
    import ths_pkg::*;

    // Run length guard: far above the slowest legal run, with full idling
    // on both sides and the receiver hold-off.
    localparam int CYCLE_LIMIT = 3_000_000;
    // Receiver hold-off length used to back the scanner up into its input.
    localparam int HOLD_CYCLES = 300;
    // Cycles to let bytes still in the input and core registers drain.
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_PHASE_BYTES = 200;

    // Header byte codes.
    localparam logic [7:0] LEN_LONG_FORM  = 8'h80;
    localparam logic [7:0] LEN_INDEFINITE = 8'h80;
    localparam logic [7:0] TAG_ZERO       = 8'h00;

    typedef enum logic [2:0] {
        PH_TAG_FIRST,
        PH_TAG_MORE,
        PH_LEN_FIRST,
        PH_LEN_MORE,
        PH_SKIP
    } t_scan_phase;

    typedef logic [7:0] t_byte_seq[$];

    logic clk;
    logic rst_n;

    ths_byte_if   byte_bus ();
    ths_cfg_if    cfg_bus ();
    ths_result_if res_bus ();

    tlv_header_scanner u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    // Scanner shadow state, updated at every accepted byte.
    t_scan_phase sc_phase;
    t_tag        sc_tag;
    t_len        sc_len;
    logic [6:0]  sc_len_left;
    t_len        sc_skip;
    t_pos        sc_pos;
    logic        sc_finished;
    t_region     region_cfg;

    t_result expected_headers[$];

    int  errors = 0;
    int  live_bytes = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a stuck handshake or a missing result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Header predictor
    // ------------------------------------------------------------------

    function automatic void scan_clear();
        sc_phase    = PH_TAG_FIRST;
        sc_tag      = '0;
        sc_len      = '0;
        sc_len_left = '0;
        sc_skip     = '0;
        sc_pos      = '0;
        sc_finished = 1'b0;
    endfunction

    // Close a header: queue its result and pick the next phase.
    function automatic void close_header(input logic indef);
        t_result    hdr;
        t_len       len;
        logic [63:0] end_pos;
        logic        eoc;
        logic        ovr;
        logic        done;

        len  = indef ? '0 : sc_len;
        eoc  = 1'b0;
        ovr  = 1'b0;
        done = 1'b0;
        if (region_cfg == '0) begin
            // Indefinite region: only a zero tag ends it.
            if (sc_tag == '0) begin
                eoc  = 1'b1;
                done = 1'b1;
            end
        end else begin
            end_pos = 64'(sc_pos) + 64'(len);
            if (end_pos > 64'(region_cfg)) begin
                ovr  = 1'b1;
                done = 1'b1;
            end else if (end_pos == 64'(region_cfg)) begin
                done = 1'b1;
            end
        end

        hdr.tag               = 32'(sc_tag);
        hdr.length            = 32'(len);
        hdr.indefinite_length = indef;
        hdr.value_offset      = (sc_pos > OFF_MAX) ? OFF_MAX[15:0] : sc_pos[15:0];
        hdr.end_of_content    = eoc;
        hdr.overrun           = ovr;
        hdr.region_done       = done;
        expected_headers.push_back(hdr);

        sc_tag      = '0;
        sc_len      = '0;
        sc_len_left = '0;
        if (done) begin
            sc_finished = 1'b1;
            sc_phase    = PH_TAG_FIRST;
        end else if (len != '0) begin
            sc_skip  = len;
            sc_phase = PH_SKIP;
        end else begin
            sc_phase = PH_TAG_FIRST;
        end
    endfunction

    // Advance the shadow scanner by one accepted byte.
    function automatic void scan_predict(input logic [7:0] b, input logic start);
        if (start)
            scan_clear();
        if (sc_finished)
            return;
        live_bytes++;
        if (sc_pos != POS_MAX)
            sc_pos++;
        case (sc_phase)
            PH_TAG_FIRST: begin
                sc_tag   = t_tag'(b);
                sc_phase = (b[4:0] == TAG_MULTI_MARK) ? PH_TAG_MORE : PH_LEN_FIRST;
            end
            PH_TAG_MORE: begin
                sc_tag = {sc_tag[TAG_BITS-9:0], b};
                if (!b[7])
                    sc_phase = PH_LEN_FIRST;
            end
            PH_LEN_FIRST: begin
                if (!b[7]) begin
                    sc_len = t_len'(b);
                    close_header(1'b0);
                end else if (b[6:0] == '0) begin
                    close_header(1'b1);
                end else begin
                    sc_len      = '0;
                    sc_len_left = b[6:0];
                    sc_phase    = PH_LEN_MORE;
                end
            end
            PH_LEN_MORE: begin
                sc_len = {sc_len[LEN_BITS-9:0], b};
                if (sc_len_left != '0)
                    sc_len_left--;
                if (sc_len_left == '0)
                    close_header(1'b0);
            end
            PH_SKIP: begin
                if (sc_skip != '0)
                    sc_skip--;
                if (sc_skip == '0)
                    sc_phase = PH_TAG_FIRST;
            end
            default: sc_phase = PH_TAG_FIRST;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Byte driver and configuration writes
    // ------------------------------------------------------------------

    // Offer one byte after a random gap; predict at the accepting edge.
    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;

        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            byte_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_bus.valid     = 1'b1;
        byte_bus.data_byte = b;
        byte_bus.start_req = start;
        do @(posedge clk); while (!byte_bus.ready);
        scan_predict(b, start);
        @(negedge clk);
    endtask

    task automatic send_seq(input t_byte_seq seq, input logic start);
        for (int i = 0; i < seq.size(); i++)
            send_byte(seq[i], start && (i == 0));
    endtask

    // Drop valid, wait for every queued header, then let the pipe drain.
    task automatic wait_idle();
        byte_bus.valid = 1'b0;
        while (expected_headers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_region_bytes(input t_region value);
        wait_idle();
        cfg_bus.valid        = 1'b1;
        cfg_bus.region_bytes = value;
        do @(posedge clk); while (!cfg_bus.ready);
        region_cfg = value;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result receiver and checker
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic check_header();
        t_result hdr;

        if (expected_headers.size() == 0) begin
            $error("header result with none expected: tag %0h", res_bus.tag);
            errors++;
            return;
        end
        hdr = expected_headers.pop_front();
        compare_field("tag", hdr.tag, res_bus.tag);
        compare_field("length", hdr.length, res_bus.length);
        compare_field("indefinite_length", 32'(hdr.indefinite_length),
                      32'(res_bus.indefinite_length));
        compare_field("value_offset", 32'(hdr.value_offset), 32'(res_bus.value_offset));
        compare_field("end_of_content", 32'(hdr.end_of_content),
                      32'(res_bus.end_of_content));
        compare_field("overrun", 32'(hdr.overrun), 32'(res_bus.overrun));
        compare_field("region_done", 32'(hdr.region_done), 32'(res_bus.region_done));
    endtask

    // Receiver: random stall per result; a hold request stalls for a long
    // stretch so the result register, the core and the input register fill.
    initial begin
        int gap;

        res_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 16) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = HOLD_CYCLES;
            end
            if (gap > 0) begin
                res_bus.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_bus.ready = 1'b1;
            do @(posedge clk); while (!res_bus.valid);
            check_header();
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Random object generation
    // ------------------------------------------------------------------

    // Build one object (tag, length, value) with random content, sometimes
    // cut short. Set stop when the rest of the region would be meaningless.
    task automatic send_object(input bit first, output bit stop);
        t_byte_seq  obj;
        int         sel;
        int         n;
        int         len;
        logic [7:0] b;

        stop = 1'b0;
        len  = 0;

        // Tag: zero, multi-byte or single byte.
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            obj.push_back(TAG_ZERO);
        end else if (sel < 5) begin
            b = 8'($urandom) | {3'b000, TAG_MULTI_MARK};
            obj.push_back(b);
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
                b    = 8'($urandom);
                b[7] = (i != n - 1);
                obj.push_back(b);
            end
        end else begin
            b = 8'($urandom);
            if (b[4:0] == TAG_MULTI_MARK)
                b[4] = 1'b0;
            obj.push_back(b);
        end

        // Length: short, indefinite, long with a small value, or long junk.
        sel = $urandom_range(0, 15);
        if (sel < 9) begin
            len = $urandom_range(0, (sel == 0) ? 127 : 24);
            obj.push_back(8'(len));
        end else if (sel < 11) begin
            obj.push_back(LEN_INDEFINITE);
        end else if (sel < 15) begin
            n   = $urandom_range(1, 4);
            len = $urandom_range(0, 40);
            obj.push_back(LEN_LONG_FORM | 8'(n));
            for (int i = n - 1; i >= 0; i--)
                obj.push_back(8'(len >> (8 * i)));
        end else begin
            // Random length bytes: the value may be huge, so end the region.
            n = $urandom_range(1, 127);
            obj.push_back(LEN_LONG_FORM | 8'(n));
            for (int i = 0; i < n; i++)
                obj.push_back(8'($urandom));
            stop = 1'b1;
        end

        for (int i = 0; i < len; i++)
            obj.push_back(8'($urandom));

        // Occasionally break the object off mid-way.
        if ($urandom_range(0, 15) == 0) begin
            n = $urandom_range(1, obj.size() - 1);
            while (obj.size() > n)
                void'(obj.pop_back());
            stop = 1'b1;
        end

        send_seq(obj, first);
    endtask

    task automatic send_region(input int n_objects);
        bit stop;

        for (int i = 0; i < n_objects; i++) begin
            send_object(i == 0, stop);
            if (stop || sc_finished)
                break;
        end
        // Trailing bytes after the region ended must be dropped.
        if (sc_finished && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(4, 40))
            send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Indefinite region: short, multi-byte and long forms, indefinite length,
    // zero tag end, and bytes ignored after the end.
    task automatic test_indefinite_region();
        write_region_bytes(16'd0);
        send_seq({8'h04, 8'h02, 8'hAA, 8'hBB}, 1'b1);
        send_seq({8'h1F, 8'h81, 8'h02, 8'h82, 8'h00, 8'h03, 8'h11, 8'h22, 8'h33}, 1'b0);
        send_seq({8'h30, LEN_INDEFINITE}, 1'b0);
        send_seq({TAG_ZERO, 8'h00}, 1'b0);
        send_seq({8'h55, 8'h01}, 1'b0);
    endtask

    // Definite region: exact fit, overrun, zero tag that does not end it.
    task automatic test_definite_region();
        write_region_bytes(16'd10);
        send_seq({8'h04, 8'h03, 8'h01, 8'h02, 8'h03}, 1'b1);
        send_seq({8'h05, 8'h03, 8'h04, 8'h05, 8'h06}, 1'b0);
        send_seq({8'h04, 8'h09}, 1'b1);
        send_seq({TAG_ZERO, 8'h00, 8'h06, 8'h00}, 1'b1);
    endtask

    // Region of one byte: the header alone runs past it.
    task automatic test_header_past_region();
        write_region_bytes(16'd1);
        send_seq({8'h04, 8'h00}, 1'b1);
        send_seq({8'h04, LEN_INDEFINITE}, 1'b1);
    endtask

    // Widest tag, all-ones length, 127 length bytes, longest short length.
    task automatic test_field_extremes();
        t_byte_seq seq;

        write_region_bytes(16'hFFFF);
        send_seq({8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00}, 1'b1);
        send_seq({8'hFE, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0);

        seq = {8'h01, 8'hFF};
        repeat (125) seq.push_back(8'h00);
        seq.push_back(8'h00);
        seq.push_back(8'h02);
        seq.push_back(8'hC3);
        seq.push_back(8'h3C);
        send_seq(seq, 1'b1);

        seq = {8'h02, 8'h7F};
        repeat (127) seq.push_back(8'($urandom));
        seq.push_back(8'h03);
        seq.push_back(8'h00);
        send_seq(seq, 1'b0);
    endtask

    // Long value in an indefinite region: the skip count runs down across
    // its low byte before the next header.
    task automatic test_long_skip();
        write_region_bytes(16'd0);
        idle_on = 1'b0;
        send_seq({8'h04, 8'h82, 8'h01, 8'h00}, 1'b1);
        repeat (256)
            send_byte(8'($urandom), 1'b0);
        send_seq({8'h04, 8'h00}, 1'b0);
        send_seq({TAG_ZERO, 8'h00}, 1'b0);
        idle_on = 1'b1;
    endtask

    // Long receiver stall while bytes keep coming, so that input ready drops.
    task automatic test_backpressure();
        write_region_bytes(16'd0);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++)
            send_seq({8'h04, 8'h00}, i == 0);
        idle_on = 1'b1;
    endtask

    // Mostly well-formed regions with random content, some noise.
    task automatic test_random_phase(input t_region cfg_value);
        int target;

        write_region_bytes(cfg_value);
        target = live_bytes + RANDOM_PHASE_BYTES;
        while (live_bytes < target) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_region($urandom_range(1, 8));
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // Hold every input at a known value before and through reset.
        rst_n                = 1'b0;
        byte_bus.valid       = 1'b0;
        byte_bus.data_byte   = '0;
        byte_bus.start_req   = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.region_bytes = '0;
        region_cfg           = '0;
        scan_clear();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_indefinite_region();
        test_definite_region();
        test_header_past_region();
        test_field_extremes();
        test_long_skip();
        test_backpressure();

        test_random_phase(16'd0);
        test_random_phase(16'd1);
        test_random_phase(16'hFFFF);
        test_random_phase(t_region'($urandom_range(8, 120)));
        test_random_phase(t_region'($urandom_range(0, 65535)));
        test_random_phase(t_region'($urandom_range(16, 64)));

        // Let the last results arrive, then watch for strays.
        wait_idle();
        repeat (10) @(negedge clk);
        if (errors == 0 && expected_headers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
